// ----- rtl/core/lms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lms_pkg
// Shared widths, register indexes, reset values and types for the shader.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int VB    = 16;          // vector component width
    localparam int DW    = 2 * VB;      // squares, dot product
    localparam int PW    = 4 * VB;      // |N|^2*|L|^2 and dot^2
    localparam int QW    = 31;          // cos^2 in Q1.30, at most 2^30
    localparam int CW    = 16;          // cosine Q1.15, at most 32768
    localparam int SQW   = QW + 2;      // running square in the root unit
    localparam int IDX_W = 3;

    localparam logic [15:0] Q_ONE       = 16'd32768;
    localparam logic [15:0] AMBIENT_Q15 = 16'd5898;

    localparam logic [IDX_W-1:0] REG_ALB_R = 3'd0;
    localparam logic [IDX_W-1:0] REG_ALB_G = 3'd1;
    localparam logic [IDX_W-1:0] REG_ALB_B = 3'd2;
    localparam logic [IDX_W-1:0] REG_METAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROUGH = 3'd4;
    localparam logic [IDX_W-1:0] REG_OCC   = 3'd5;

    localparam logic [15:0] RST_ALB_R = 16'd23593;
    localparam logic [15:0] RST_ALB_G = 16'd24248;
    localparam logic [15:0] RST_ALB_B = 16'd25559;
    localparam logic [15:0] RST_METAL = 16'd1638;
    localparam logic [15:0] RST_ROUGH = 16'd23593;
    localparam logic [15:0] RST_OCC   = 16'd32768;

    // material values, each already saturated to 1.0
    typedef struct packed {
        logic [15:0] alb_r;
        logic [15:0] alb_g;
        logic [15:0] alb_b;
        logic [15:0] metal;
        logic [15:0] rough;
        logic [15:0] occ;
    } mat_t;

    typedef logic [2:0][VB-1:0] vec_t;

    function automatic logic [15:0] sat_one(input logic [15:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lms_vec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lms_vec
// Vector front end: zero-vector fixup, magnitudes, squared lengths, dot
// product and the two wide products feeding the divider. Four stages.
// ----------------------------------------------------------------------------
module lms_vec (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire lms_pkg::vec_t           in_n,
    input  wire lms_pkg::vec_t           in_l,
    output logic                         out_valid,
    output logic [lms_pkg::PW-1:0]       out_p,
    output logic [lms_pkg::PW-1:0]       out_d2
);

    lms_pkg::vec_t n_fix, l_fix;
    lms_pkg::vec_t nmag_reg, lmag_reg;
    logic [2:0] sx_reg;
    logic [2:0][lms_pkg::DW-1:0] nsq_reg, lsq_reg, pr_reg;
    logic [2:0] sxb_reg;
    logic [lms_pkg::DW-1:0] nn_reg, ll_reg, d_reg;
    logic [lms_pkg::DW-1:0] pos_sum, neg_sum;
    logic [lms_pkg::PW-1:0] p_reg, d2_reg;
    logic [3:0] v_reg;

    always_comb begin
        n_fix = in_n;
        l_fix = in_l;
        if (in_n == '0) n_fix[1] = lms_pkg::VB'(1);
        if (in_l == '0) l_fix[1] = lms_pkg::VB'(1);
    end

    always_comb begin
        pos_sum = '0;
        neg_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (sxb_reg[i]) neg_sum = neg_sum + pr_reg[i];
            else            pos_sum = pos_sum + pr_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nmag_reg[i] <= n_fix[i][lms_pkg::VB-1] ? (~n_fix[i] + 1'b1) : n_fix[i];
                lmag_reg[i] <= l_fix[i][lms_pkg::VB-1] ? (~l_fix[i] + 1'b1) : l_fix[i];
                sx_reg[i]   <= n_fix[i][lms_pkg::VB-1] ^ l_fix[i][lms_pkg::VB-1];
                nsq_reg[i]  <= nmag_reg[i] * nmag_reg[i];
                lsq_reg[i]  <= lmag_reg[i] * lmag_reg[i];
                pr_reg[i]   <= nmag_reg[i] * lmag_reg[i];
            end
            sxb_reg <= sx_reg;
            nn_reg  <= nsq_reg[0] + nsq_reg[1] + nsq_reg[2];
            ll_reg  <= lsq_reg[0] + lsq_reg[1] + lsq_reg[2];
            // facing away: dot of zero or less forces the cosine to zero
            d_reg   <= (pos_sum > neg_sum) ? (pos_sum - neg_sum) : '0;
            p_reg   <= nn_reg * ll_reg;
            d2_reg  <= d_reg * d_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign out_p     = p_reg;
    assign out_d2    = d2_reg;

endmodule
`default_nettype wire

// ----- rtl/core/lms_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lms_div
// Pipelined restoring divider: floor(d2 * 2^30 / p), one quotient bit per
// stage. d2 <= p holds, so the integer bit is the first stage.
// ----------------------------------------------------------------------------
module lms_div (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [lms_pkg::PW-1:0]  in_p,
    input  wire logic [lms_pkg::PW-1:0]  in_d2,
    output logic                         out_valid,
    output logic [lms_pkg::QW-1:0]       out_q
);

    localparam int N = lms_pkg::QW;

    logic [N-1:0]               v_reg;
    logic [lms_pkg::PW-1:0]     r_reg [N];
    logic [lms_pkg::PW-1:0]     p_reg [N];
    logic [N-1:0]               q_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= in_p;
            if (in_d2 >= in_p) begin
                r_reg[0] <= in_d2 - in_p;
                q_reg[0] <= N'(1) << (N - 1);
            end else begin
                r_reg[0] <= in_d2;
                q_reg[0] <= '0;
            end
        end
    end

    for (genvar j = 1; j < N; j++) begin : g_stage
        logic [lms_pkg::PW:0] rs;
        assign rs = {r_reg[j-1], 1'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[j] <= p_reg[j-1];
                if (rs >= {1'b0, p_reg[j-1]}) begin
                    r_reg[j] <= lms_pkg::PW'(rs - {1'b0, p_reg[j-1]});
                    q_reg[j] <= q_reg[j-1] | (N'(1) << (N - 1 - j));
                end else begin
                    r_reg[j] <= rs[lms_pkg::PW-1:0];
                    q_reg[j] <= q_reg[j-1];
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_q     = q_reg[N-1];

endmodule
`default_nettype wire

// ----- rtl/core/lms_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lms_sqrt
// Pipelined integer square root, one result bit per stage; the running
// square is updated incrementally so each stage is one add and compare.
// ----------------------------------------------------------------------------
module lms_sqrt (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [lms_pkg::QW-1:0]  in_q,
    output logic                         out_valid,
    output logic [lms_pkg::CW-1:0]       out_c
);

    localparam int N = lms_pkg::CW;

    logic [N-1:0]               v_reg;
    logic [lms_pkg::QW-1:0]     q_reg  [N];
    logic [N-1:0]               c_reg  [N];
    logic [lms_pkg::SQW-1:0]    sq_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        logic [lms_pkg::QW-1:0]  q_in;
        logic [N-1:0]            c_in;
        logic [lms_pkg::SQW-1:0] sq_in, cand;
        if (j == 0) begin : g_first
            assign q_in  = in_q;
            assign c_in  = '0;
            assign sq_in = '0;
        end else begin : g_next
            assign q_in  = q_reg[j-1];
            assign c_in  = c_reg[j-1];
            assign sq_in = sq_reg[j-1];
        end
        // (c + 2^K)^2 = c^2 + c*2^(K+1) + 2^(2K)
        assign cand = sq_in + (lms_pkg::SQW'(c_in) << (K + 1))
                    + (lms_pkg::SQW'(1) << (2 * K));
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j] <= q_in;
                if (cand <= lms_pkg::SQW'(q_in)) begin
                    c_reg[j]  <= c_in | (N'(1) << K);
                    sq_reg[j] <= cand;
                end else begin
                    c_reg[j]  <= c_in;
                    sq_reg[j] <= sq_in;
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_c     = c_reg[N-1];

endmodule
`default_nettype wire

// ----- rtl/core/lms_shade.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lms_shade
// Intensity from ambient, diffuse and specular terms (Q2.30), then albedo
// scaling and saturation. Five stages, the last is the output register.
// ----------------------------------------------------------------------------
module lms_shade (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [lms_pkg::CW-1:0]  in_c,
    input  wire lms_pkg::mat_t           mat,
    output logic                         out_valid,
    output logic [2:0][15:0]             out_rgb
);

    logic [4:0]  v_reg;
    logic [30:0] amb_reg, diff_reg, mc_reg;
    logic [30:0] amb2_reg, diff2_reg;
    logic [31:0] spec_reg;
    logic [31:0] inten_reg;
    logic [2:0][47:0] prod_reg;
    logic [2:0][15:0] rgb_reg;
    logic [47:0] spec_full;
    logic [16:0] rough_inv;

    assign rough_inv = 17'd65536 - {1'b0, mat.rough};
    assign spec_full = mc_reg * rough_inv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            amb_reg   <= {15'd0, mat.occ} * {15'd0, lms_pkg::AMBIENT_Q15};
            diff_reg  <= {15'd0, lms_pkg::Q_ONE - mat.metal} * {15'd0, in_c};
            mc_reg    <= {15'd0, mat.metal} * {15'd0, in_c};
            amb2_reg  <= amb_reg;
            diff2_reg <= diff_reg;
            spec_reg  <= spec_full[47:16];
            inten_reg <= {1'b0, amb2_reg} + {1'b0, diff2_reg} + spec_reg;
            prod_reg[0] <= mat.alb_r * inten_reg;
            prod_reg[1] <= mat.alb_g * inten_reg;
            prod_reg[2] <= mat.alb_b * inten_reg;
            for (int k = 0; k < 3; k++) begin
                rgb_reg[k] <= (prod_reg[k][47:46] != 2'b00) ? 16'hFFFF : prod_reg[k][45:30];
            end
        end
    end

    assign out_valid = v_reg[4];
    assign out_rgb   = rgb_reg;

endmodule
`default_nettype wire

// ----- rtl/core/lambert_metal_shade.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lambert_metal_shade
// Per-pixel Lambert shading with a metallic split, exact Q1.15 cosine.
// ----------------------------------------------------------------------------
// Pipeline: 4 vector, 31 divider, 16 square root and 5 shading stages from
// input transfer to m_tvalid.
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds while the output register is full and m_tready is low.
// Reset: synchronous, active low; clears all valid bits and loads the
// material registers with their defaults. No clearing pass.
module lambert_metal_shade (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // normal_x, normal_y, normal_z, light_x, light_y, light_z
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // shade_red, shade_green, shade_blue
    output logic [47:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] alb_r_reg, alb_g_reg, alb_b_reg, metal_reg, rough_reg, occ_reg;
    logic [lms_pkg::IDX_W-1:0] idx;
    logic en, wr;
    lms_pkg::vec_t vn, vl;
    lms_pkg::mat_t mat;
    logic vec_v, div_v, sq_v;
    logic [lms_pkg::PW-1:0] vec_p, vec_d2;
    logic [lms_pkg::QW-1:0] div_q;
    logic [lms_pkg::CW-1:0] cos_c;
    logic [2:0][15:0] rgb;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alb_r_reg <= lms_pkg::RST_ALB_R;
            alb_g_reg <= lms_pkg::RST_ALB_G;
            alb_b_reg <= lms_pkg::RST_ALB_B;
            metal_reg <= lms_pkg::RST_METAL;
            rough_reg <= lms_pkg::RST_ROUGH;
            occ_reg   <= lms_pkg::RST_OCC;
        end else if (wr) begin
            case (idx)
                lms_pkg::REG_ALB_R: alb_r_reg <= pwdata[15:0];
                lms_pkg::REG_ALB_G: alb_g_reg <= pwdata[15:0];
                lms_pkg::REG_ALB_B: alb_b_reg <= pwdata[15:0];
                lms_pkg::REG_METAL: metal_reg <= pwdata[15:0];
                lms_pkg::REG_ROUGH: rough_reg <= pwdata[15:0];
                lms_pkg::REG_OCC:   occ_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            lms_pkg::REG_ALB_R: prdata = {16'd0, alb_r_reg};
            lms_pkg::REG_ALB_G: prdata = {16'd0, alb_g_reg};
            lms_pkg::REG_ALB_B: prdata = {16'd0, alb_b_reg};
            lms_pkg::REG_METAL: prdata = {16'd0, metal_reg};
            lms_pkg::REG_ROUGH: prdata = {16'd0, rough_reg};
            lms_pkg::REG_OCC:   prdata = {16'd0, occ_reg};
            default:            prdata = '0;
        endcase
    end

    assign mat.alb_r = lms_pkg::sat_one(alb_r_reg);
    assign mat.alb_g = lms_pkg::sat_one(alb_g_reg);
    assign mat.alb_b = lms_pkg::sat_one(alb_b_reg);
    assign mat.metal = lms_pkg::sat_one(metal_reg);
    assign mat.rough = lms_pkg::sat_one(rough_reg);
    assign mat.occ   = lms_pkg::sat_one(occ_reg);

    // whole pipeline moves unless a finished pixel is stuck at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign vn = s_tdata[47:0];
    assign vl = s_tdata[95:48];

    lms_vec u_vec (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .in_n(vn), .in_l(vl),
        .out_valid(vec_v), .out_p(vec_p), .out_d2(vec_d2)
    );

    lms_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vec_v), .in_p(vec_p), .in_d2(vec_d2),
        .out_valid(div_v), .out_q(div_q)
    );

    lms_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div_v), .in_q(div_q),
        .out_valid(sq_v), .out_c(cos_c)
    );

    lms_shade u_shade (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_v), .in_c(cos_c), .mat(mat),
        .out_valid(m_tvalid), .out_rgb(rgb)
    );

    assign m_tdata = rgb;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled pixel changed or lost");
    a_cos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_v |-> cos_c <= lms_pkg::Q_ONE)
        else $error("cosine above one");
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_v |-> div_q <= (lms_pkg::QW'(1) << (lms_pkg::QW - 1)))
        else $error("cos^2 quotient above one");
`endif

endmodule
`default_nettype wire
